// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define SEFR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define SEFR_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`else

`define SEFR_ASSERT(label, prop, msg)
`define SEFR_NEVER(label, cond, msg)

`endif

`endif

// ===== hdl/sefr_pkg.sv =====
// ----------------------------------------------------------------------------
// sefr_pkg
// Types and constants of the start/end framed receiver with XOR check.
// ----------------------------------------------------------------------------
package sefr_pkg;

    // Largest payload a frame may carry
    localparam int MAX_PAYLOAD = 2;

    localparam int PAYLOAD_IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int COUNT_W       = 3;
    localparam int LENGTH_W      = 2;
    localparam int BYTE_W        = 8;
    localparam int CFG_INDEX_W   = 2;

    localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'h7F;
    localparam logic [BYTE_W-1:0] END_BYTE_RESET   = 8'h7E;
    localparam logic [LENGTH_W-1:0] MAX_LENGTH_RESET = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_CMD   = 3'd1,
        PH_LEN   = 3'd2,
        PH_DATA  = 3'd3,
        PH_CHECK = 3'd4,
        PH_PAD   = 3'd5,
        PH_END   = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        ST_GOOD      = 2'd0,
        ST_BAD_END   = 2'd1,
        ST_BAD_CHECK = 2'd2
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_START_BYTE = 2'd0,
        CFG_END_BYTE   = 2'd1,
        CFG_MAX_LENGTH = 2'd2
    } cfg_index_t;

endpackage

// ===== hdl/sefr_channels.sv =====
// ----------------------------------------------------------------------------
// sefr channels
// Valid/ready channels for received bytes and for completed frames.
// ----------------------------------------------------------------------------
interface sefr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sefr_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] command;
    logic [1:0] payload_length;
    logic [7:0] payload_first;
    logic [7:0] payload_second;
    logic [1:0] frame_status;

    modport source (
        output valid, output command, output payload_length,
        output payload_first, output payload_second, output frame_status,
        input  ready
    );
    modport sink (
        input  valid, input command, input payload_length,
        input  payload_first, input payload_second, input frame_status,
        output ready
    );
endinterface

// ===== hdl/sof_eof_xor_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// sof_eof_xor_frame_receiver
// Parses start/command/length/payload/check/pad/end frames from a byte
// stream and reports each completed frame with an end and XOR check status.
// ----------------------------------------------------------------------------
//
//   channel | dir | request carries
//   --------+-----+-------------------------------------------------------
//   rx      | in  | rx_byte
//   frame   | out | command, payload_length, payload_first,
//           |     | payload_second, frame_status
//   cfg     | in  | cfg_we, cfg_index, cfg_data (write only)
//
// The parser state and the frame result register are updated at the
// edge that accepts each byte.
// A new byte is taken every cycle while the result register is empty or
// being drained; a frame result held by a stalled sink blocks rx.
// Reset is asynchronous, active low; configuration returns to start 0x7F,
// end 0x7E, max length 2, and the parser goes idle.
// Payload storage has no reset; it is always filled before it is read.
//
`include "assert_macros.svh"

module sof_eof_xor_frame_receiver
    import sefr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]      cfg_data,
    sefr_rx_if.sink                rx,
    sefr_frame_if.source           frame
);

    localparam logic [COUNT_W:0]       PAYLOAD_LIMIT = (COUNT_W+1)'(MAX_PAYLOAD);
    localparam logic [BYTE_W-1:0]      PAYLOAD_CAP   = BYTE_W'(MAX_PAYLOAD);
    localparam logic [PAYLOAD_IDX_W-1:0] FIRST_IDX   = '0;
    localparam logic [PAYLOAD_IDX_W-1:0] SECOND_IDX  =
        PAYLOAD_IDX_W'((MAX_PAYLOAD >= 2) ? 1 : 0);

    // Configuration
    logic [BYTE_W-1:0]   start_byte_reg;
    logic [BYTE_W-1:0]   end_byte_reg;
    logic [LENGTH_W-1:0] max_length_reg;

    // Parser state
    phase_t              phase_reg, phase_next;
    logic [BYTE_W-1:0]   command_hold_reg, command_hold_next;
    logic [LENGTH_W-1:0] length_hold_reg, length_hold_next;
    logic [COUNT_W-1:0]  byte_count_reg, byte_count_next;
    logic [BYTE_W-1:0]   check_hold_reg, check_hold_next;
    logic [BYTE_W-1:0]   running_xor_reg, running_xor_next;
    logic [BYTE_W-1:0]   payload_store [MAX_PAYLOAD];

    // Result register
    logic                res_valid_reg, res_valid_next;
    logic [BYTE_W-1:0]   res_command_reg;
    logic [LENGTH_W-1:0] res_length_reg;
    logic [BYTE_W-1:0]   res_first_reg;
    logic [BYTE_W-1:0]   res_second_reg;
    status_t             res_status_reg;

    logic                accept;
    logic                res_load;
    status_t             status_calc;
    logic [BYTE_W-1:0]   length_limit;
    logic [COUNT_W-1:0]  count_inc;
    logic                store_we;
    logic [BYTE_W-1:0]   first_calc;
    logic [BYTE_W-1:0]   second_calc;

    // Take a byte whenever the result register is free or draining.
    assign rx.ready = !res_valid_reg || frame.ready;
    assign accept   = rx.valid && rx.ready;

    // ---------------- configuration writes ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= START_BYTE_RESET;
            end_byte_reg   <= END_BYTE_RESET;
            max_length_reg <= MAX_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_BYTE: start_byte_reg <= cfg_data;
                CFG_END_BYTE:   end_byte_reg   <= cfg_data;
                CFG_MAX_LENGTH: max_length_reg <= cfg_data[LENGTH_W-1:0];
                default:        ; // drop writes to unused indexes
            endcase
        end
    end

    // Effective length limit: the register, capped by the payload storage.
    always_comb
    begin
        if ({6'd0, max_length_reg} > PAYLOAD_CAP)
        begin
            length_limit = PAYLOAD_CAP;
        end
        else
        begin
            length_limit = {6'd0, max_length_reg};
        end
    end

    assign count_inc = byte_count_reg + 3'd1;

    // Judge the end byte first; the checksum only counts with a right end.
    always_comb
    begin
        if (rx.rx_byte != end_byte_reg)
        begin
            status_calc = ST_BAD_END;
        end
        else if (running_xor_reg != check_hold_reg)
        begin
            status_calc = ST_BAD_CHECK;
        end
        else
        begin
            status_calc = ST_GOOD;
        end
    end

    // Payload fields past the frame length read as zero.
    assign first_calc  = (length_hold_reg >= 2'd1) ? payload_store[FIRST_IDX] : '0;
    assign second_calc = (length_hold_reg >= 2'd2 && MAX_PAYLOAD >= 2)
                         ? payload_store[SECOND_IDX] : '0;

    // ---------------- parser next state ----------------
    always_comb
    begin
        phase_next        = phase_reg;
        command_hold_next = command_hold_reg;
        length_hold_next  = length_hold_reg;
        byte_count_next   = byte_count_reg;
        check_hold_next   = check_hold_reg;
        running_xor_next  = running_xor_reg;
        store_we          = 1'b0;
        res_load          = 1'b0;

        if (accept)
        begin
            if (rx.rx_byte == start_byte_reg)
            begin
                // Resynchronize on a start byte anywhere, even in end position.
                phase_next = PH_CMD;
            end
            else
            begin
                unique case (phase_reg)
                    PH_CMD:
                    begin
                        command_hold_next = rx.rx_byte;
                        running_xor_next  = rx.rx_byte;
                        phase_next        = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        if (rx.rx_byte > length_limit)
                        begin
                            // Drop oversize frames silently.
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            length_hold_next = rx.rx_byte[LENGTH_W-1:0];
                            running_xor_next = running_xor_reg ^ rx.rx_byte;
                            byte_count_next  = '0;
                            phase_next = (rx.rx_byte[LENGTH_W-1:0] == 2'd0)
                                         ? PH_CHECK : PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        store_we         = ({1'b0, byte_count_reg} < PAYLOAD_LIMIT);
                        running_xor_next = running_xor_reg ^ rx.rx_byte;
                        byte_count_next  = count_inc;
                        if (count_inc >= {1'b0, length_hold_reg})
                        begin
                            phase_next = PH_CHECK;
                        end
                    end
                    PH_CHECK:
                    begin
                        check_hold_next = rx.rx_byte;
                        phase_next      = PH_PAD;
                    end
                    PH_PAD:
                    begin
                        phase_next = PH_END;
                    end
                    PH_END:
                    begin
                        res_load   = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    default:
                    begin
                        // Idle and the unused code both wait for a start byte.
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            command_hold_reg <= '0;
            length_hold_reg  <= '0;
            byte_count_reg   <= '0;
            check_hold_reg   <= '0;
            running_xor_reg  <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            command_hold_reg <= command_hold_next;
            length_hold_reg  <= length_hold_next;
            byte_count_reg   <= byte_count_next;
            check_hold_reg   <= check_hold_next;
            running_xor_reg  <= running_xor_next;
        end
    end

    // Payload storage, no reset.
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            payload_store[byte_count_reg[PAYLOAD_IDX_W-1:0]] <= rx.rx_byte;
        end
    end

    // ---------------- result register ----------------
    always_comb
    begin
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (frame.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_command_reg <= command_hold_reg;
            res_length_reg  <= length_hold_reg;
            res_first_reg   <= first_calc;
            res_second_reg  <= second_calc;
            res_status_reg  <= status_calc;
        end
    end

    assign frame.valid          = res_valid_reg;
    assign frame.command        = res_command_reg;
    assign frame.payload_length = res_length_reg;
    assign frame.payload_first  = res_first_reg;
    assign frame.payload_second = res_second_reg;
    assign frame.frame_status   = res_status_reg;

    // ---------------- assertions ----------------
    `SEFR_ASSERT(a_start_resyncs,
        (accept && rx.rx_byte == start_byte_reg) |=> (phase_reg == PH_CMD),
        "start byte did not resynchronize the parser")
    `SEFR_ASSERT(a_result_from_end,
        $rose(res_valid_reg) |-> $past(accept && phase_reg == PH_END),
        "frame result appeared without an end-position byte")
    `SEFR_NEVER(a_status_code,
        res_valid_reg && res_status_reg == 2'd3,
        "frame result carries an undefined status")
    `SEFR_NEVER(a_length_cap,
        phase_reg == PH_DATA && {1'b0, length_hold_reg} > PAYLOAD_LIMIT[LENGTH_W:0],
        "payload phase with a length beyond storage")
    `SEFR_NEVER(a_no_overwrite,
        res_valid_reg && !frame.ready && res_load,
        "pending frame result overwritten")

endmodule

// ===== tb/tb_sof_eof_xor_frame_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sof_eof_xor_frame_receiver
// Feeds byte streams with good, damaged, cut and oversize frames to the
// receiver and checks every reported frame against a byte-level parser
// kept in the testbench, over several register settings.
// ----------------------------------------------------------------------------
module tb_sof_eof_xor_frame_receiver
    import sefr_pkg::*;
();

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 10;
    localparam int SETTLE_CYCLES  = 4;     // result register holds a single frame
    localparam int HOLD_OFF_CYCLES = 150;  // long sink stall to back up rx
    localparam int TIMEOUT_CYCLES = 200000;

    // Directed opening stream, parsed with the reset settings:
    //   good frame with two payload bytes at the byte extremes,
    //   zero-length frame with a wrong end byte,
    //   one-byte frame with a bad check byte,
    //   start byte in the end position, then a length above the maximum.
    localparam logic [7:0] DIRECTED_BYTES [29] = '{
        8'h7F, 8'h00, 8'h02, 8'hFF, 8'h00, 8'hFD, 8'hFF, 8'h7E,
        8'h7F, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h55,
        8'h7F, 8'h12, 8'h01, 8'h34, 8'h00, 8'h80, 8'h7E,
        8'h7F, 8'h22, 8'h00, 8'h22, 8'h5A, 8'h7F, 8'h01, 8'h03
    };

    // One reported frame, laid out as on the frame channel
    typedef struct packed {
        logic [7:0] command;
        logic [1:0] payload_length;
        logic [7:0] payload_first;
        logic [7:0] payload_second;
        logic [1:0] frame_status;
    } frame_result_t;

    // Shapes of the random frames
    typedef enum int {
        SHAPE_GOOD,
        SHAPE_OVERSIZE,
        SHAPE_BAD_CHECK,
        SHAPE_BAD_END,
        SHAPE_START_AT_END,
        SHAPE_TRUNCATED,
        SHAPE_NOISE
    } frame_shape_t;

    // ------------------------------------------------------------------------
    // Frame tracker: parses every accepted byte the way the receiver should,
    // queues the frames it must report and checks them as they come out.
    // ------------------------------------------------------------------------
    class frame_tracker;
        logic [7:0]    start_byte;
        logic [7:0]    end_byte;
        logic [1:0]    max_length;

        phase_t        phase;
        logic [7:0]    command_hold;
        logic [1:0]    length_hold;
        logic [2:0]    byte_count;
        logic [7:0]    payload_store [MAX_PAYLOAD];
        logic [7:0]    check_hold;
        logic [7:0]    running_xor;

        frame_result_t awaited_frames [$];
        int            error_count;

        function new();
            start_byte   = START_BYTE_RESET;
            end_byte     = END_BYTE_RESET;
            max_length   = MAX_LENGTH_RESET;
            phase        = PH_IDLE;
            command_hold = '0;
            length_hold  = '0;
            byte_count   = '0;
            check_hold   = '0;
            running_xor  = '0;
            error_count  = 0;
            foreach (payload_store[i]) payload_store[i] = '0;
        endfunction

        function void apply_register(cfg_index_t idx, logic [7:0] value);
            case (idx)
                CFG_START_BYTE: start_byte = value;
                CFG_END_BYTE:   end_byte   = value;
                CFG_MAX_LENGTH: max_length = value[1:0];
                default: ;
            endcase
        endfunction

        // Advance the parser by one received byte
        function void parse_byte(logic [7:0] b);
            int unsigned   limit;
            frame_result_t done;
            if (b == start_byte) begin
                phase = PH_CMD;
                return;
            end
            case (phase)
                PH_CMD: begin
                    command_hold = b;
                    running_xor  = b;
                    phase        = PH_LEN;
                end
                PH_LEN: begin
                    limit = (max_length > MAX_PAYLOAD) ? MAX_PAYLOAD : max_length;
                    if (b > limit) begin
                        phase = PH_IDLE;
                    end
                    else begin
                        length_hold = b[1:0];
                        running_xor = running_xor ^ b;
                        byte_count  = '0;
                        phase       = (length_hold == 0) ? PH_CHECK : PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (byte_count < MAX_PAYLOAD)
                        payload_store[byte_count[PAYLOAD_IDX_W-1:0]] = b;
                    running_xor = running_xor ^ b;
                    byte_count  = byte_count + 3'd1;
                    if (byte_count >= length_hold) phase = PH_CHECK;
                end
                PH_CHECK: begin
                    check_hold = b;
                    phase      = PH_PAD;
                end
                PH_PAD: phase = PH_END;
                PH_END: begin
                    done.command        = command_hold;
                    done.payload_length = length_hold;
                    done.payload_first  = (length_hold >= 1) ? payload_store[0] : 8'h00;
                    done.payload_second = (length_hold >= 2) ? payload_store[1] : 8'h00;
                    if (b != end_byte)
                        done.frame_status = ST_BAD_END;
                    else if (running_xor != check_hold)
                        done.frame_status = ST_BAD_CHECK;
                    else
                        done.frame_status = ST_GOOD;
                    awaited_frames.push_back(done);
                    phase = PH_IDLE;
                end
                default: phase = PH_IDLE;
            endcase
        endfunction

        function void check_frame(frame_result_t got);
            frame_result_t want;
            if (awaited_frames.size() == 0) begin
                error_count++;
                $display("%0t: unexpected frame cmd=%02h len=%0d p0=%02h p1=%02h status=%0d",
                         $time, got.command, got.payload_length, got.payload_first,
                         got.payload_second, got.frame_status);
                return;
            end
            want = awaited_frames.pop_front();
            if (got !== want) begin
                error_count++;
                $display("%0t: frame mismatch: expected cmd=%02h len=%0d p0=%02h p1=%02h status=%0d",
                         $time, want.command, want.payload_length, want.payload_first,
                         want.payload_second, want.frame_status);
                $display("%0t:                 actual   cmd=%02h len=%0d p0=%02h p1=%02h status=%0d",
                         $time, got.command, got.payload_length, got.payload_first,
                         got.payload_second, got.frame_status);
            end
        endfunction

        function int outstanding();
            return awaited_frames.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]      cfg_data;

    sefr_rx_if    rx_ch ();
    sefr_frame_if frame_ch ();

    frame_tracker tracker = new();

    bit idle_enable;        // shared by sender and sink; off in the last phase
    bit hold_off_request;   // ask the sink for one long stall
    int bytes_sent;

    always begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    sof_eof_xor_frame_receiver uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx        (rx_ch),
        .frame     (frame_ch)
    );

    // ------------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge. A byte request feeds
    // the parser; a frame request is checked against the oldest awaited frame.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (rx_ch.valid && rx_ch.ready)
                tracker.parse_byte(rx_ch.rx_byte);
            if (frame_ch.valid && frame_ch.ready)
                tracker.check_frame('{frame_ch.command, frame_ch.payload_length,
                                      frame_ch.payload_first, frame_ch.payload_second,
                                      frame_ch.frame_status});
        end
    end

    // ------------------------------------------------------------------------
    // Sink: drive ready at the falling edge. Stall in short random bursts
    // while idling is on, and once for a long stretch when asked, so that a
    // held frame backs up the byte input.
    // ------------------------------------------------------------------------
    initial begin
        frame_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                frame_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                frame_ch.ready <= 1'b1;
            end
            else if (idle_enable && $urandom_range(0, 5) == 0) begin
                frame_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
                frame_ch.ready <= 1'b1;
            end
            else begin
                frame_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks. Each runs from a falling edge and returns on one; the
    // caller either offers the next byte or drops valid at that same edge.
    // ------------------------------------------------------------------------

    // Offer one byte, hold it until taken, then maybe pause
    task automatic send_byte(input logic [7:0] value);
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= value;
        @(posedge clk);
        while (!rx_ch.ready) @(posedge clk);
        @(negedge clk);
        bytes_sent++;
        if (idle_enable && $urandom_range(0, 4) == 0) begin
            rx_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
    endtask

    // Drop valid and wait until every awaited frame has come out
    task automatic wait_for_frames();
        rx_ch.valid <= 1'b0;
        while (tracker.outstanding() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write one register; keep the parser copy in step
    task automatic set_register(input cfg_index_t idx, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        tracker.apply_register(idx, value);
        @(negedge clk);
    endtask

    // Random byte that does not restart the frame
    function automatic logic [7:0] data_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == tracker.start_byte);
        return b;
    endfunction

    // Mostly well-formed frames; the rest damaged, cut short or plain noise
    function automatic frame_shape_t pick_shape();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)  return SHAPE_OVERSIZE;
        if (roll < 18) return SHAPE_BAD_CHECK;
        if (roll < 26) return SHAPE_BAD_END;
        if (roll < 30) return SHAPE_START_AT_END;
        if (roll < 40) return SHAPE_TRUNCATED;
        if (roll < 48) return SHAPE_NOISE;
        return SHAPE_GOOD;
    endfunction

    task automatic send_random_frame();
        logic [7:0]   frame_bytes [$];
        logic [7:0]   cmd;
        logic [7:0]   len;
        logic [7:0]   sum;
        logic [7:0]   value;
        int unsigned  limit;
        int unsigned  n_payload;
        int unsigned  keep;
        frame_shape_t shape;

        shape = pick_shape();
        if (shape == SHAPE_NOISE) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            return;
        end

        limit = (tracker.max_length > MAX_PAYLOAD) ? MAX_PAYLOAD : tracker.max_length;
        cmd   = data_byte();
        if (shape == SHAPE_OVERSIZE) begin
            len       = 8'($urandom_range(limit + 1, 255));
            n_payload = $urandom_range(0, MAX_PAYLOAD);
        end
        else begin
            len       = 8'($urandom_range(0, limit));
            n_payload = len;
        end

        frame_bytes = '{tracker.start_byte, cmd, len};
        sum = cmd ^ len;
        repeat (n_payload) begin
            value = data_byte();
            frame_bytes.push_back(value);
            sum = sum ^ value;
        end
        // flip some check bits, never none
        if (shape == SHAPE_BAD_CHECK) sum = sum ^ 8'($urandom_range(1, 255));
        frame_bytes.push_back(sum);
        frame_bytes.push_back(data_byte());   // pad

        if (shape == SHAPE_BAD_END)
            frame_bytes.push_back(tracker.end_byte ^ 8'($urandom_range(1, 255)));
        else if (shape == SHAPE_START_AT_END)
            frame_bytes.push_back(tracker.start_byte);
        else
            frame_bytes.push_back(tracker.end_byte);

        // cut the frame somewhere after the start byte, before the end byte
        if (shape == SHAPE_TRUNCATED) begin
            keep = $urandom_range(1, frame_bytes.size() - 2);
            frame_bytes = frame_bytes[0:keep];
        end

        foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
    endtask

    // One register setting: drain, write all registers, then stream frames
    task automatic run_phase(input logic [7:0] start_value, input logic [7:0] end_value,
                             input logic [1:0] max_value, input int n_bytes,
                             input bit idling, input bit with_hold_off);
        int target;
        wait_for_frames();
        set_register(CFG_START_BYTE, start_value);
        set_register(CFG_END_BYTE, end_value);
        set_register(CFG_MAX_LENGTH, {6'd0, max_value});
        if (with_hold_off) hold_off_request = 1'b1;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target) begin
            // idle in stretches, with quiet runs in between
            idle_enable = idling && ($urandom_range(0, 3) != 0);
            send_random_frame();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        rst_n            = 1'b0;
        rx_ch.valid      = 1'b0;
        rx_ch.rx_byte    = '0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_START_BYTE;
        cfg_data         = '0;
        idle_enable      = 1'b1;
        hold_off_request = 1'b0;
        bytes_sent       = 0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // directed stream with the reset settings
        foreach (DIRECTED_BYTES[i]) send_byte(DIRECTED_BYTES[i]);

        // reset values, then both byte extremes, then max length out of
        // range with a long sink stall, then zero length, and a final phase
        // at full rate
        run_phase(START_BYTE_RESET, END_BYTE_RESET, MAX_LENGTH_RESET, 150, 1'b1, 1'b0);
        run_phase(8'h00, 8'hFF, 2'd1, 170, 1'b1, 1'b0);
        run_phase(8'hFF, 8'h00, 2'd3, 170, 1'b1, 1'b1);
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 2'd0,
                  170, 1'b1, 1'b0);
        run_phase(START_BYTE_RESET, END_BYTE_RESET, 2'd2, 160, 1'b0, 1'b0);
        wait_for_frames();

        if (tracker.error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
